// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the byte ring buffer.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on the rising edge, switched off while reset is asserted.
`define BRB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define BRB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BRB_ASSERT(lbl, clk, rst_n, prop, msg)
`define BRB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/brb_pkg.sv =====
// Shared constants and opcode type for the byte ring buffer.
// No dependencies; imported by the top level.
`default_nettype none

package brb_pkg;

	localparam int DEPTH  = 256;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = AW + 1;
	localparam int BYTE_W = 8;

	typedef enum logic [2:0] {
		OP_CLEAR    = 3'd0,
		OP_WRITE    = 3'd1,
		OP_READ     = 3'd2,
		OP_PEEK     = 3'd3,
		OP_SEARCH   = 3'd4,
		OP_CHECKSUM = 3'd5
	} op_t;

endpackage

`default_nettype wire

// ===== rtl/brb_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies; one instance holds the ring buffer bytes.
`default_nettype none

module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   addr,
	input  wire logic [WIDTH-1:0]           wdata,
	output logic      [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read share one address
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/byte_ring_buffer_with_search_sum.sv =====
// Sequence: clear, write and rejected ops go straight to the output state; read and peek
// pass through ST_WAIT for the RAM read; search and checksum walk ST_SCAN, one RAM read a cycle.
// One transaction in flight; s_tready returns once the result enters the output register,
// which waits in ST_OUT while the held output has not been taken.
// Reset (arst_n, async, active low) zeroes pointers and count; the byte RAM is not cleared,
// as only entries written since the last clear are ever read.
`default_nettype none
`include "assert_macros.svh"

module byte_ring_buffer_with_search_sum import brb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [7:0] data_byte, [15:8] base_offset, [24:16] end_offset, [31:25] zero
	input  wire logic [31:0] s_tdata,
	// [2:0] opcode
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] out_byte, [15:8] found_offset, [24:16] fill_count, [31:25] zero
	output logic      [31:0] m_tdata,
	// [0] error_flag
	output logic      [0:0]  m_tuser
);

	typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_SCAN, ST_OUT} state_t;

	state_t              state_q;
	logic [AW-1:0]       head_q, tail_q;
	logic [CW-1:0]       count_q;
	op_t                 op_q;
	logic [BYTE_W-1:0]   dbyte_q;
	logic [CW-1:0]       k_q, lim_q;
	logic                pend_s1;
	logic [AW-1:0]       koff_s1;
	logic                hit_q;
	logic [BYTE_W-1:0]   sum_q, obyte_q;
	logic [AW-1:0]       found_q;
	logic                err_q;
	logic                m_tvalid_q;
	logic [31:0]         m_tdata_q;
	logic [0:0]          m_tuser_q;

	logic                acc, full, empty, start_bad, span_bad, scan_go, out_ready;
	op_t                 in_op;
	logic [BYTE_W-1:0]   in_byte;
	logic [AW-1:0]       in_start;
	logic [CW-1:0]       in_end, start_ext;
	logic                ram_we;
	logic [AW-1:0]       ram_addr;
	logic [BYTE_W-1:0]   ram_rdata;

	// input decode and range checks
	always_comb begin
		acc       = s_tvalid && s_tready;
		in_op     = op_t'(s_tuser);
		in_byte   = s_tdata[7:0];
		in_start  = s_tdata[15:8];
		in_end    = s_tdata[24:16];
		start_ext = {1'b0, in_start};
		full      = (count_q == CW'(DEPTH));
		empty     = (count_q == '0);
		start_bad = (start_ext >= count_q);
		span_bad  = start_bad || (in_end > count_q) || (in_end <= start_ext);
		scan_go   = (state_q == ST_SCAN) && (k_q != lim_q) && !hit_q;
		out_ready = !m_tvalid_q || m_tready;
	end

	assign s_tready = (state_q == ST_IDLE);

	// RAM address: scan walk, else chosen by the incoming opcode
	always_comb begin
		ram_we = acc && (in_op == OP_WRITE);
		if (state_q == ST_SCAN) begin
			ram_addr = tail_q + k_q[AW-1:0];
		end else begin
			case (in_op)
				OP_WRITE: ram_addr = head_q;
				OP_READ:  ram_addr = tail_q;
				default:  ram_addr = tail_q + in_start;
			endcase
		end
	end

	brb_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (in_byte),
		.rdata (ram_rdata)
	);

	// sequencer, pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			op_q       <= OP_CLEAR;
			dbyte_q    <= '0;
			k_q        <= '0;
			lim_q      <= '0;
			pend_s1    <= 1'b0;
			koff_s1    <= '0;
			hit_q      <= 1'b0;
			sum_q      <= '0;
			obyte_q    <= '0;
			found_q    <= '0;
			err_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else begin
			// scan issue stage
			pend_s1 <= scan_go;
			if (scan_go) begin
				k_q     <= k_q + CW'(1);
				koff_s1 <= k_q[AW-1:0];
			end

			// scan data stage: match or accumulate once read data lands
			if (pend_s1 && !hit_q) begin
				if (op_q == OP_SEARCH) begin
					if (ram_rdata == dbyte_q) begin
						hit_q   <= 1'b1;
						found_q <= koff_s1;
					end
				end else begin
					sum_q <= sum_q + ram_rdata;
				end
			end

			// output taken; a new result loaded in ST_OUT takes its place
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						op_q    <= in_op;
						dbyte_q <= in_byte;
						k_q     <= start_ext;
						hit_q   <= 1'b0;
						sum_q   <= '0;
						found_q <= '0;
						obyte_q <= '0;
						err_q   <= 1'b0;
						state_q <= ST_OUT;
						case (in_op)
							OP_CLEAR: begin
								head_q  <= '0;
								tail_q  <= '0;
								count_q <= '0;
							end
							OP_WRITE: begin
								head_q <= head_q + AW'(1);
								if (full) begin
									// overwrite oldest: tail follows, count stays
									tail_q <= tail_q + AW'(1);
									err_q  <= 1'b1;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							OP_READ: begin
								if (empty) begin
									err_q <= 1'b1;
								end else begin
									tail_q  <= tail_q + AW'(1);
									count_q <= count_q - CW'(1);
									state_q <= ST_WAIT;
								end
							end
							OP_PEEK: begin
								if (start_bad) begin
									err_q <= 1'b1;
								end else begin
									state_q <= ST_WAIT;
								end
							end
							OP_SEARCH: begin
								if (start_bad) begin
									err_q <= 1'b1;
								end else begin
									lim_q   <= count_q;
									state_q <= ST_SCAN;
								end
							end
							OP_CHECKSUM: begin
								if (span_bad) begin
									err_q <= 1'b1;
								end else begin
									lim_q   <= in_end;
									state_q <= ST_SCAN;
								end
							end
							default: begin
								err_q <= 1'b1;
							end
						endcase
					end
				end
				ST_WAIT: begin
					obyte_q <= ram_rdata;
					state_q <= ST_OUT;
				end
				ST_SCAN: begin
					// done once the walk ends or a match is in, with no read in flight
					if (!pend_s1 && ((k_q == lim_q) || hit_q)) begin
						if (op_q == OP_SEARCH) begin
							err_q <= !hit_q;
						end else begin
							obyte_q <= sum_q;
						end
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						m_tdata_q  <= {7'b0, count_q, found_q, obyte_q};
						m_tuser_q  <= err_q;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`BRB_ASSERT(a_count_max, clk, arst_n, count_q <= CW'(DEPTH), "fill count above depth")
	`BRB_ASSERT(a_ptr_gap, clk, arst_n, head_q == tail_q + count_q[AW-1:0], "head, tail and count disagree")
	`BRB_ASSERT(a_pend_scan, clk, arst_n, !pend_s1 || state_q == ST_SCAN || state_q == ST_OUT, "scan read outside a scan")
	`BRB_ASSERT(a_full_write, clk, arst_n, (acc && in_op == OP_WRITE && full) |=> (count_q == CW'(DEPTH)), "full write changed count")

endmodule

`default_nettype wire
